[rtl/fxa_pkg.sv]
// Shared types, opcodes and constants for the Q24.8 fixed-point ALU.
package fxa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W = 32;
    localparam int MAG_W = WORD_W;
    // dividend magnitude after the fraction shift
    localparam int NUM_W = MAG_W + FRAC_BITS;
    // quotient width; also the number of divider stages
    localparam int QUO_W = NUM_W + 1;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_GT = 4'd4,
        OP_LT = 4'd5,
        OP_GE = 4'd6,
        OP_LE = 4'd7,
        OP_EQ = 4'd8,
        OP_NE = 4'd9,
        OP_MIN = 4'd10,
        OP_MAX = 4'd11,
        OP_INC = 4'd12,
        OP_DEC = 4'd13,
        OP_TOINT = 4'd14,
        OP_NONE = 4'd15
    } op_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic flag;
        logic overflow;
        logic div_zero;
    } result_t;

endpackage

[rtl/fxa_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, stall-aware.
module fxa_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  logic [fxa_pkg::QUO_W-1:0]  numer,
    input  logic [fxa_pkg::MAG_W:0]    denom,
    input  fxa_pkg::result_t           side_in,
    output logic                       out_valid,
    output logic [fxa_pkg::QUO_W-1:0]  quotient,
    output fxa_pkg::result_t           side_out
);
    import fxa_pkg::*;

    localparam int REM_W = MAG_W + 2;

    logic [QUO_W-1:0] valid_reg;
    logic [QUO_W-1:0][REM_W-1:0] rem_reg;
    logic [QUO_W-1:0][QUO_W-1:0] num_reg;
    logic [QUO_W-1:0][MAG_W:0] den_reg;
    result_t side_reg [QUO_W];

    logic [QUO_W-1:0][REM_W-1:0] rem_next;
    logic [QUO_W-1:0][QUO_W-1:0] num_next;

    always_comb
    begin
        for (int s = 0; s < QUO_W; s++)
        begin
            logic [REM_W-1:0] rin;
            logic [QUO_W-1:0] nin;
            logic [MAG_W:0] din;
            logic [REM_W-1:0] sh;
            rin = (s == 0) ? '0 : rem_reg[s == 0 ? 0 : s-1];
            nin = (s == 0) ? numer : num_reg[s == 0 ? 0 : s-1];
            din = (s == 0) ? denom : den_reg[s == 0 ? 0 : s-1];
            sh = {rin[REM_W-2:0], nin[QUO_W-1]};
            if (sh >= {1'b0, din})
            begin
                rem_next[s] = sh - {1'b0, din};
                num_next[s] = {nin[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = sh;
                num_next[s] = {nin[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < QUO_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                den_reg[s] <= (s == 0) ? denom : den_reg[s == 0 ? 0 : s-1];
                side_reg[s] <= (s == 0) ? side_in : side_reg[s == 0 ? 0 : s-1];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quotient = num_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule

[rtl/fixed_point_q24_8_alu.sv]
// Top level of the Q24.8 fixed-point ALU pipeline.
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | op, operand_a, operand_b
// out     | out_valid | out_stall | value, flag, overflow, div_zero
// Accepts one word per cycle while the output does not stall; every op runs through
// the same QUO_W + 3 register stages (decode, product, 41 quotient-bit stages, output).
// Reset clears only valid bits. A stall on the output freezes the whole pipe;
// in_stall follows out_stall only when the last stage holds a word.
module fixed_point_q24_8_alu
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [3:0]                        op,
    input  logic signed [fxa_pkg::WORD_W-1:0] operand_a,
    input  logic signed [fxa_pkg::WORD_W-1:0] operand_b,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [fxa_pkg::WORD_W-1:0] value,
    output logic                              flag,
    output logic                              overflow,
    output logic                              div_zero
);
    import fxa_pkg::*;

    localparam logic [63:0] MAXV = 64'sd2147483647;
    localparam logic [63:0] MINMAG = 64'd2147483648;

    logic advance;
    assign advance = !(out_valid && out_stall);
    assign in_stall = !advance;

    // stage 1: decode, magnitudes, simple ops
    logic v1_reg;
    op_t op1_reg;
    logic neg1_reg;
    logic [MAG_W:0] ma1_reg, mb1_reg;
    result_t r1_reg;
    logic [MAG_W:0] ma, mb;
    result_t r1_next;
    logic signed [WORD_W:0] sa, sb, t;

    always_comb
    begin
        sa = {operand_a[WORD_W-1], operand_a};
        sb = {operand_b[WORD_W-1], operand_b};
        ma = operand_a[WORD_W-1] ? -sa : sa;
        mb = operand_b[WORD_W-1] ? -sb : sb;
        r1_next = '0;
        t = '0;
        case (op_t'(op))
            OP_ADD, OP_SUB, OP_INC, OP_DEC:
            begin
                case (op_t'(op))
                    OP_ADD: t = sa + sb;
                    OP_SUB: t = sa - sb;
                    OP_INC: t = sa + 33'sd1;
                    default: t = sa - 33'sd1;
                endcase
                if (t[WORD_W] != t[WORD_W-1])
                begin
                    r1_next.overflow = 1'b1;
                    r1_next.value = t[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}}
                                              : {1'b0, {(WORD_W-1){1'b1}}};
                end
                else
                    r1_next.value = t[WORD_W-1:0];
            end
            OP_GT: r1_next.flag = operand_a > operand_b;
            OP_LT: r1_next.flag = operand_a < operand_b;
            OP_GE: r1_next.flag = operand_a >= operand_b;
            OP_LE: r1_next.flag = operand_a <= operand_b;
            OP_EQ: r1_next.flag = operand_a == operand_b;
            OP_NE: r1_next.flag = operand_a != operand_b;
            OP_MIN: r1_next.value = (operand_a < operand_b) ? operand_a : operand_b;
            OP_MAX: r1_next.value = (operand_a > operand_b) ? operand_a : operand_b;
            OP_TOINT: r1_next.value = operand_a >>> FRAC_BITS;
            OP_DIV: r1_next.div_zero = (operand_b == '0);
            default: r1_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (advance)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg <= op_t'(op);
            neg1_reg <= operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
            ma1_reg <= ma;
            mb1_reg <= mb;
            r1_reg <= r1_next;
        end
    end

    // stage 2: product register; divider setup
    logic v2_reg;
    op_t op2_reg;
    logic neg2_reg;
    logic [2*MAG_W-1:0] prod2_reg;
    result_t r2_reg;
    logic [QUO_W-1:0] dnum;
    logic [MAG_W:0] dden;

    // divide 2n by d; halving floor(2n/d) + 1 rounds half away from zero
    always_comb
    begin
        dnum = {ma1_reg[MAG_W-1:0], {FRAC_BITS{1'b0}}, 1'b0};
        dden = mb1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (advance)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op2_reg <= op1_reg;
            neg2_reg <= neg1_reg;
            prod2_reg <= {{MAG_W{1'b0}}, ma1_reg[MAG_W-1:0]} *
                         {{MAG_W{1'b0}}, mb1_reg[MAG_W-1:0]};
            r2_reg <= r1_reg;
        end
    end

    // divider runs on the whole pipe; side band carries mul/other results
    result_t side_in, side_out;
    logic dv;
    logic [QUO_W-1:0] quo;
    logic dneg_out, ddiv_out;
    logic [QUO_W-1:0] dnum_d;
    logic [MAG_W:0] dden_d;

    // numerator and divisor held one stage to line up with the product
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dnum_d <= dnum;
            dden_d <= dden;
        end
    end

    // mul result finishes in stage 3 and rides the side band
    logic [63:0] pq;
    result_t mres;
    always_comb
    begin
        pq = prod2_reg + (64'd1 << (FRAC_BITS - 1));
        pq = pq >> FRAC_BITS;
        mres = r2_reg;
        if (op2_reg == OP_MUL)
        begin
            mres = '0;
            if (neg2_reg)
            begin
                if (pq > MINMAG)
                begin
                    mres.overflow = 1'b1;
                    mres.value = {1'b1, {(WORD_W-1){1'b0}}};
                end
                else
                    mres.value = -pq[WORD_W-1:0];
            end
            else if (pq > MAXV)
            begin
                mres.overflow = 1'b1;
                mres.value = {1'b0, {(WORD_W-1){1'b1}}};
            end
            else
                mres.value = pq[WORD_W-1:0];
        end
        side_in = mres;
    end

    fxa_divider u_div
    (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .in_valid(v2_reg),
        .numer(dnum_d),
        .denom(dden_d == '0 ? {{MAG_W{1'b0}}, 1'b1} : dden_d),
        .side_in(side_in),
        .out_valid(dv),
        .quotient(quo),
        .side_out(side_out)
    );

    // sign and real-divide mark travel in small shift lines beside the divider
    logic [QUO_W-1:0] sgn_reg;
    logic [QUO_W-1:0] dsel_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sgn_reg <= {sgn_reg[QUO_W-2:0], neg2_reg};
            dsel_reg <= {dsel_reg[QUO_W-2:0], (op2_reg == OP_DIV && !r2_reg.div_zero)};
        end
    end
    assign dneg_out = sgn_reg[QUO_W-1];
    assign ddiv_out = dsel_reg[QUO_W-1];

    // final stage: quo = floor(2n/d), so (quo + 1) / 2 is n/d rounded; saturate
    logic vo_reg;
    result_t ro_reg;
    result_t ro_next;
    logic [QUO_W:0] qr;
    always_comb
    begin
        ro_next = side_out;
        qr = '0;
        if (ddiv_out)
        begin
            qr = ({1'b0, quo} + {{QUO_W{1'b0}}, 1'b1}) >> 1;
            ro_next = '0;
            if (dneg_out)
            begin
                if (qr > {1'b0, MINMAG[QUO_W-1:0]})
                begin
                    ro_next.overflow = 1'b1;
                    ro_next.value = {1'b1, {(WORD_W-1){1'b0}}};
                end
                else
                    ro_next.value = -qr[WORD_W-1:0];
            end
            else if (qr > {1'b0, MAXV[QUO_W-1:0]})
            begin
                ro_next.overflow = 1'b1;
                ro_next.value = {1'b0, {(WORD_W-1){1'b1}}};
            end
            else
                ro_next.value = qr[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (advance)
            vo_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            ro_reg <= ro_next;
    end

    assign out_valid = vo_reg;
    assign value = ro_reg.value;
    assign flag = ro_reg.flag;
    assign overflow = ro_reg.overflow;
    assign div_zero = ro_reg.div_zero;

`ifndef NO_ASSERTIONS
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(div_zero && (overflow || flag)))
        else $error("div_zero with another flag");
    a_dz_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_zero |-> value == '0)
        else $error("div_zero with nonzero value");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("stalled result changed");
`endif

endmodule
